FILE: sv/cpu8_pkg.sv
// Shared types, flag positions and decode tables for the cpu8 execute block.
// No dependencies; imported by cpu8_register_alu_execute_top and cpu8_exec.
package cpu8_pkg;

    localparam int DATA_W   = 8;
    localparam int FLAG_W   = 6;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 56;

    // internal flag vector: N V D I Z C, bit 5 down to bit 0
    localparam int FLAG_N = 5;
    localparam int FLAG_V = 4;
    localparam int FLAG_D = 3;
    localparam int FLAG_I = 2;
    localparam int FLAG_Z = 1;
    localparam int FLAG_C = 0;

    localparam logic [DATA_W-1:0] SP_RESET   = 8'hFD;
    localparam logic [FLAG_W-1:0] FLAG_RESET = 6'b000100;

    // legal addressing-mode bits per operation row
    localparam logic [7:0] GRP2_MODES [8] = '{8'hAE, 8'hAE, 8'hAE, 8'hAE,
                                              8'h2A, 8'hAB, 8'hAA, 8'hAA};
    localparam logic [7:0] GRP0_MODES [8] = '{8'h00, 8'h0A, 8'h00, 8'h00,
                                              8'h2A, 8'hAB, 8'h0B, 8'h0B};

    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] sp;
        logic [FLAG_W-1:0] f;
    } t_regs;

    typedef struct packed {
        logic              store_en;
        logic [DATA_W-1:0] store_data;
        logic              branch;
        logic              unknown;
    } t_exec_out;

    function automatic logic [DATA_W-1:0] pack_status(input logic [FLAG_W-1:0] fl);
        return {fl[FLAG_N], fl[FLAG_V], 1'b1, 1'b0,
                fl[FLAG_D], fl[FLAG_I], fl[FLAG_Z], fl[FLAG_C]};
    endfunction

endpackage

FILE: sv/cpu8_register_alu_execute_top.sv
// Top level of the cpu8 execute stage: input register, register file, result register.
// Depends on cpu8_pkg and cpu8_exec.
//
// Usage:
//   Slave stream carries one instruction word per handshake; master stream
//   returns one result word per instruction, in order.
//   A word is accepted on a rising edge with tvalid and tready both high.
//   An accepted word is held in the input register, then passes the ALU into
//   the result register, which drives the master side.
//   Throughput: one instruction per cycle while results are taken; the
//   register file update and the ALU sit in one combinational pass between
//   the input and result registers, so a word can follow in every cycle.
//   Stall: while the result waits on i_m_axis_tready the input register
//   holds one more word; tready on the slave side drops only when both are
//   full and the result is not taken.
//   Reset (i_rst_n low, synchronous): both stages empty, A = X = Y = 0,
//   SP = 0xFD, I set and all other flags clear.
//   Results report A, X, Y, SP and status after each instruction, plus any
//   memory write, the branch decision and an unknown-opcode flag.
module cpu8_register_alu_execute_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] func, [15:8] operand
    input  logic [15:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] acc_out, [15:8] x_out, [23:16] y_out, [31:24] status_out,
    // [39:32] sp_out, [40] store_enable, [48:41] store_data,
    // [49] branch_taken, [50] unknown_opcode, [55:51] zero
    output logic [55:0] o_m_axis_tdata
);
    import cpu8_pkg::*;

    logic                  r_in_valid;
    logic [IN_TDATA_W-1:0] r_in_data;
    logic                  r_out_valid;
    t_regs                 r_regs;
    t_regs                 n_regs;
    t_exec_out             r_res;
    t_exec_out             n_res;
    logic                  in_fire;
    logic                  exec_fire;

    assign exec_fire       = r_in_valid & (~r_out_valid | i_m_axis_tready);
    assign o_s_axis_tready = ~r_in_valid | exec_fire;
    assign in_fire         = i_s_axis_tvalid & o_s_axis_tready;

    cpu8_exec u_exec (
        .i_func    (r_in_data[7:0]),
        .i_operand (r_in_data[15:8]),
        .i_regs    (r_regs),
        .o_regs    (n_regs),
        .o_res     (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_regs.a    <= '0;
            r_regs.x    <= '0;
            r_regs.y    <= '0;
            r_regs.sp   <= SP_RESET;
            r_regs.f    <= FLAG_RESET;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (exec_fire) begin
                r_in_valid <= 1'b0;
            end
            if (exec_fire) begin
                r_out_valid <= 1'b1;
                r_regs      <= n_regs;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_data <= i_s_axis_tdata;
        end
        if (exec_fire) begin
            r_res <= n_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_res.unknown, r_res.branch, r_res.store_data,
                              r_res.store_en, r_regs.sp, pack_status(r_regs.f),
                              r_regs.y, r_regs.x, r_regs.a};

endmodule

FILE: sv/cpu8_exec.sv
// Combinational decode and execute of one opcode against the register file.
// Depends on cpu8_pkg (register and result structs, mode tables).
module cpu8_exec (
    input  logic [7:0]           i_func,
    input  logic [7:0]           i_operand,
    input  cpu8_pkg::t_regs      i_regs,
    output cpu8_pkg::t_regs      o_regs,
    output cpu8_pkg::t_exec_out  o_res
);
    import cpu8_pkg::*;

    localparam logic [7:0] OP_NOP = 8'hEA;
    localparam logic [7:0] OP_DEY = 8'h88;
    localparam logic [7:0] OP_DEX = 8'hCA;
    localparam logic [7:0] OP_INY = 8'hC8;
    localparam logic [7:0] OP_INX = 8'hE8;
    localparam logic [7:0] OP_TAY = 8'hA8;
    localparam logic [7:0] OP_TYA = 8'h98;
    localparam logic [7:0] OP_TXA = 8'h8A;
    localparam logic [7:0] OP_TAX = 8'hAA;
    localparam logic [7:0] OP_TXS = 8'h9A;
    localparam logic [7:0] OP_TSX = 8'hBA;
    localparam logic [7:0] OP_CLC = 8'h18;
    localparam logic [7:0] OP_SEC = 8'h38;
    localparam logic [7:0] OP_CLI = 8'h58;
    localparam logic [7:0] OP_SEI = 8'h78;
    localparam logic [7:0] OP_CLD = 8'hD8;
    localparam logic [7:0] OP_SED = 8'hF8;
    localparam logic [7:0] OP_CLV = 8'hB8;
    localparam logic [7:0] OP_STA_IMM = 8'h89;

    localparam logic [4:0] BRANCH_PATTERN = 5'h10;

    localparam logic [1:0] GRP_CTL = 2'd0;
    localparam logic [1:0] GRP_ALU = 2'd1;
    localparam logic [1:0] GRP_RMW = 2'd2;

    localparam logic [2:0] MODE_ACC = 3'd2;

    localparam logic [1:0] BR_N = 2'd0;
    localparam logic [1:0] BR_V = 2'd1;
    localparam logic [1:0] BR_C = 2'd2;
    localparam logic [1:0] BR_Z = 2'd3;

    localparam logic [2:0] ROW_ORA = 3'd0;
    localparam logic [2:0] ROW_AND = 3'd1;
    localparam logic [2:0] ROW_EOR = 3'd2;
    localparam logic [2:0] ROW_ADC = 3'd3;
    localparam logic [2:0] ROW_STA = 3'd4;
    localparam logic [2:0] ROW_LDA = 3'd5;
    localparam logic [2:0] ROW_CMP = 3'd6;
    localparam logic [2:0] ROW_SBC = 3'd7;

    localparam logic [2:0] ROW_ASL = 3'd0;
    localparam logic [2:0] ROW_ROL = 3'd1;
    localparam logic [2:0] ROW_LSR = 3'd2;
    localparam logic [2:0] ROW_ROR = 3'd3;
    localparam logic [2:0] ROW_STX = 3'd4;
    localparam logic [2:0] ROW_LDX = 3'd5;
    localparam logic [2:0] ROW_DEC = 3'd6;
    localparam logic [2:0] ROW_INC = 3'd7;

    localparam logic [2:0] ROW_BIT = 3'd1;
    localparam logic [2:0] ROW_STY = 3'd4;
    localparam logic [2:0] ROW_LDY = 3'd5;
    localparam logic [2:0] ROW_CPY = 3'd6;

    function automatic logic [FLAG_W-1:0] set_zn(input logic [FLAG_W-1:0] fl,
                                                 input logic [DATA_W-1:0] v);
        logic [FLAG_W-1:0] r;
        r = fl;
        r[FLAG_Z] = (v == '0);
        r[FLAG_N] = v[DATA_W-1];
        return r;
    endfunction

    function automatic logic [FLAG_W-1:0] compare(input logic [FLAG_W-1:0] fl,
                                                  input logic [DATA_W-1:0] rg,
                                                  input logic [DATA_W-1:0] m);
        logic [DATA_W:0]   diff;
        logic [FLAG_W-1:0] r;
        diff = {1'b0, rg} - {1'b0, m};
        r = fl;
        r[FLAG_C] = ~diff[DATA_W];
        return set_zn(r, diff[DATA_W-1:0]);
    endfunction

    logic [1:0]        grp;
    logic [2:0]        row;
    logic [2:0]        mode;
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] sp;
    logic [FLAG_W-1:0] f;
    logic [DATA_W:0]   t;
    logic [DATA_W-1:0] src;
    logic [DATA_W-1:0] res;
    logic              cin;
    logic              on_acc;
    logic              sel_flag;
    logic              known;
    logic              st_en;
    logic [DATA_W-1:0] st_d;
    logic              br;

    assign grp  = i_func[1:0];
    assign row  = i_func[7:5];
    assign mode = i_func[4:2];
    assign m    = i_operand;

    always_comb begin
        a        = i_regs.a;
        x        = i_regs.x;
        y        = i_regs.y;
        sp       = i_regs.sp;
        f        = i_regs.f;
        t        = '0;
        src      = '0;
        res      = '0;
        cin      = i_regs.f[FLAG_C];
        on_acc   = (mode == MODE_ACC);
        sel_flag = 1'b0;
        known    = 1'b1;
        st_en    = 1'b0;
        st_d     = '0;
        br       = 1'b0;

        case (i_func)
            OP_NOP: begin
            end
            OP_DEY: begin y = y - 8'd1; f = set_zn(f, y); end
            OP_DEX: begin x = x - 8'd1; f = set_zn(f, x); end
            OP_INY: begin y = y + 8'd1; f = set_zn(f, y); end
            OP_INX: begin x = x + 8'd1; f = set_zn(f, x); end
            OP_TAY: begin y = a; f = set_zn(f, y); end
            OP_TYA: begin a = y; f = set_zn(f, a); end
            OP_TXA: begin a = x; f = set_zn(f, a); end
            OP_TAX: begin x = a; f = set_zn(f, x); end
            OP_TXS: begin sp = x; end
            OP_TSX: begin x = sp; f = set_zn(f, x); end
            OP_CLC: f[FLAG_C] = 1'b0;
            OP_SEC: f[FLAG_C] = 1'b1;
            OP_CLI: f[FLAG_I] = 1'b0;
            OP_SEI: f[FLAG_I] = 1'b1;
            OP_CLD: f[FLAG_D] = 1'b0;
            OP_SED: f[FLAG_D] = 1'b1;
            OP_CLV: f[FLAG_V] = 1'b0;
            default: begin
                if (i_func[4:0] == BRANCH_PATTERN) begin
                    case (i_func[7:6])
                        BR_N:    sel_flag = f[FLAG_N];
                        BR_V:    sel_flag = f[FLAG_V];
                        BR_C:    sel_flag = f[FLAG_C];
                        BR_Z:    sel_flag = f[FLAG_Z];
                        default: sel_flag = 1'b0;
                    endcase
                    br = (sel_flag == i_func[5]);
                end else if (grp == GRP_ALU && i_func != OP_STA_IMM) begin
                    case (row)
                        ROW_ORA: begin a = a | m; f = set_zn(f, a); end
                        ROW_AND: begin a = a & m; f = set_zn(f, a); end
                        ROW_EOR: begin a = a ^ m; f = set_zn(f, a); end
                        ROW_ADC: begin
                            t = {1'b0, a} + {1'b0, m} + {{DATA_W{1'b0}}, cin};
                            f[FLAG_C] = t[DATA_W];
                            f[FLAG_V] = (a[7] ^ t[7]) & (m[7] ^ t[7]);
                            a = t[DATA_W-1:0];
                            f = set_zn(f, a);
                        end
                        ROW_STA: begin st_en = 1'b1; st_d = a; end
                        ROW_LDA: begin a = m; f = set_zn(f, a); end
                        ROW_CMP: f = compare(f, a, m);
                        ROW_SBC: begin
                            t = {1'b0, a} - {1'b0, m} - {{DATA_W{1'b0}}, ~cin};
                            f[FLAG_C] = ~t[DATA_W];
                            f[FLAG_V] = (a[7] ^ t[7]) & (~m[7] ^ t[7]);
                            a = t[DATA_W-1:0];
                            f = set_zn(f, a);
                        end
                        default: begin
                        end
                    endcase
                end else if (grp == GRP_RMW && GRP2_MODES[row][mode]) begin
                    src = on_acc ? a : m;
                    case (row)
                        ROW_ASL, ROW_ROL: begin
                            f[FLAG_C] = src[7];
                            res = {src[6:0], (row == ROW_ROL) & cin};
                        end
                        ROW_LSR, ROW_ROR: begin
                            f[FLAG_C] = src[0];
                            res = {(row == ROW_ROR) & cin, src[7:1]};
                        end
                        ROW_STX: begin st_en = 1'b1; st_d = x; end
                        ROW_LDX: begin x = m; f = set_zn(f, x); end
                        ROW_DEC: res = m - 8'd1;
                        ROW_INC: res = m + 8'd1;
                        default: res = '0;
                    endcase
                    if (row != ROW_STX && row != ROW_LDX) begin
                        f = set_zn(f, res);
                        if (on_acc) begin
                            a = res;
                        end else begin
                            st_en = 1'b1;
                            st_d  = res;
                        end
                    end
                end else if (grp == GRP_CTL && GRP0_MODES[row][mode]) begin
                    case (row)
                        ROW_BIT: begin
                            f[FLAG_Z] = ((a & m) == '0);
                            f[FLAG_V] = m[6];
                            f[FLAG_N] = m[7];
                        end
                        ROW_STY: begin st_en = 1'b1; st_d = y; end
                        ROW_LDY: begin y = m; f = set_zn(f, y); end
                        ROW_CPY: f = compare(f, y, m);
                        default: f = compare(f, x, m);
                    endcase
                end else begin
                    known = 1'b0;
                end
            end
        endcase
    end

    assign o_regs.a  = a;
    assign o_regs.x  = x;
    assign o_regs.y  = y;
    assign o_regs.sp = sp;
    assign o_regs.f  = f;

    assign o_res.store_en   = st_en;
    assign o_res.store_data = st_d;
    assign o_res.branch     = br;
    assign o_res.unknown    = ~known;

endmodule

FILE: sv/cpu8_checker.sv
// Port-level checks for the cpu8 execute stage, bound to the top level.
// Depends on cpu8_register_alu_execute_top port names only.
module cpu8_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [55:0] o_m_axis_tdata
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result word changed while stalled");

    a_status_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[29] && !o_m_axis_tdata[28])
        else $error("status constant bits wrong");

    a_store_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[40] |-> o_m_axis_tdata[48:41] == 8'h00)
        else $error("store data nonzero without store enable");

    a_unknown_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[50] |-> !o_m_axis_tdata[40] && !o_m_axis_tdata[49])
        else $error("unknown opcode with store or branch");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind cpu8_register_alu_execute_top cpu8_checker u_cpu8_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
